FILE: src/swfn_pkg.sv
`timescale 1ns / 1ps

package swfn_pkg;

    // Defaults for the top-level parameters
    localparam int MAX_WINDOW_DEF  = 64;
    localparam int SAMPLE_BITS_DEF = 32;

    // Fixed field widths
    localparam int WIN_BITS = 7;
    localparam int RES_BITS = 32;

    // Window size after reset
    localparam logic [WIN_BITS-1:0] WINDOW_RST = 7'd1;

    // Per-step commands to the negative-sample queue
    typedef struct packed {
        logic pop;
        logic push;
        logic clear;
    } t_fifo_ctl;

endpackage

FILE: src/swfn_if.sv
`timescale 1ns / 1ps

interface swfn_smp_if #(
    parameter int SAMPLE_BITS = swfn_pkg::SAMPLE_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          end_of_sequence;

    modport source (output valid, output sample, output end_of_sequence, input ready);
    modport sink   (input valid, input sample, input end_of_sequence, output ready);
endinterface

interface swfn_res_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [swfn_pkg::RES_BITS-1:0] first_negative;
    logic                                 sequence_end;

    modport source (output valid, output first_negative, output sequence_end, input ready);
    modport sink   (input valid, input first_negative, input sequence_end, output ready);
endinterface

FILE: src/swfn_fifo.sv
`timescale 1ns / 1ps

module swfn_fifo #(
    parameter int MAX_WINDOW  = swfn_pkg::MAX_WINDOW_DEF,
    parameter int SAMPLE_BITS = swfn_pkg::SAMPLE_BITS_DEF,
    parameter int PW          = $clog2(2 * MAX_WINDOW)
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  swfn_pkg::t_fifo_ctl    i_ctl,
    input  logic [SAMPLE_BITS-1:0] i_wr_val,
    input  logic [PW-1:0]          i_wr_pos,
    output logic                   o_head_vld,
    output logic [PW-1:0]          o_head_pos,
    output logic                   o_nxt_vld,
    output logic [SAMPLE_BITS-1:0] o_nxt_val
);
    import swfn_pkg::*;

    localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int CW = $clog2(MAX_WINDOW + 1);
    localparam int EW = SAMPLE_BITS + PW;

    // Entries head and head+1 sit in registers; head+2 comes from the
    // registered memory read (or a bypass of a same-cycle write).
    logic [EW-1:0] mem [MAX_WINDOW];

    logic [AW-1:0] r_head, n_head;
    logic [AW-1:0] r_tail, n_tail;
    logic [CW-1:0] r_count, n_count;
    logic [EW-1:0] r_h0, n_h0;
    logic [EW-1:0] r_h1, n_h1;
    logic [EW-1:0] r_rd_mem;
    logic          r_byp;
    logic [EW-1:0] r_byp_ent;

    logic [CW-1:0] cnt_mid;
    logic          push_eff;
    logic [EW-1:0] wr_ent;
    logic [EW-1:0] rd_ent;
    logic [AW-1:0] head_inc;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] rd_addr_1;
    logic [CW-1:0] cnt_pre;

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        ptr_inc = (p == AW'(MAX_WINDOW - 1)) ? '0 : p + AW'(1);
    endfunction

    assign wr_ent   = {i_wr_val, i_wr_pos};
    assign rd_ent   = r_byp ? r_byp_ent : r_rd_mem;
    assign cnt_mid  = r_count - CW'(i_ctl.pop);
    assign push_eff = i_ctl.push && (32'(cnt_mid) < MAX_WINDOW);
    assign cnt_pre  = cnt_mid + CW'(push_eff);
    assign head_inc = ptr_inc(r_head);

    always_comb begin
        // shift the front window by the pop, then drop the push into the first free slot
        n_h0 = i_ctl.pop ? r_h1 : r_h0;
        n_h1 = i_ctl.pop ? rd_ent : r_h1;
        if (push_eff && 32'(cnt_mid) == 0) begin
            n_h0 = wr_ent;
        end
        if (push_eff && 32'(cnt_mid) == 1) begin
            n_h1 = wr_ent;
        end

        if (i_ctl.clear) begin
            n_head  = '0;
            n_tail  = '0;
            n_count = '0;
        end else begin
            n_head  = i_ctl.pop ? head_inc : r_head;
            n_tail  = push_eff ? ptr_inc(r_tail) : r_tail;
            n_count = cnt_pre;
        end
    end

    assign rd_addr_1 = ptr_inc(n_head);
    assign rd_addr   = ptr_inc(rd_addr_1);

    always_ff @(posedge i_clk) begin
        if (push_eff) begin
            mem[r_tail] <= wr_ent;
        end
        r_rd_mem  <= mem[rd_addr];
        r_byp     <= push_eff && (32'(cnt_mid) == 2);
        r_byp_ent <= wr_ent;
        r_h0      <= n_h0;
        r_h1      <= n_h1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    assign o_head_vld = (r_count != '0);
    assign o_head_pos = r_h0[PW-1:0];
    assign o_nxt_vld  = (cnt_pre != '0);
    assign o_nxt_val  = n_h0[EW-1:PW];

endmodule

FILE: src/sliding_window_first_negative.sv
`timescale 1ns / 1ps

// Oldest negative sample in a sliding window.
//
// Channels: i_smp carries one signed sample and an end-of-sequence flag per
// request; o_res carries the oldest negative sample still inside the last
// window_size samples (or 0) and a copy of the end-of-sequence flag. Both use
// valid/ready; a request moves on a clock edge with valid and ready high.
// i_cfg_we / i_cfg_wdata write window_size; write it only while idle.
//
// A sample is taken into the input register, processed from there into the
// result register and shown on o_res from it. Throughput is one sample per
// cycle while o_res does not stall: each sample does at most one queue pop,
// one push and one head read, all against registered queue front entries.
// window_size above MAX_WINDOW acts as MAX_WINDOW. No result is given until
// window_size samples of a sequence have arrived, nor while window_size is 0.
//
// Reset clears the counters and the queue pointers and sets window_size to 1;
// queue storage is not cleared. When o_res stalls, the result register holds
// and one more sample waits in the input register before i_smp.ready drops.
module sliding_window_first_negative #(
    parameter int MAX_WINDOW  = swfn_pkg::MAX_WINDOW_DEF,
    parameter int SAMPLE_BITS = swfn_pkg::SAMPLE_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    swfn_smp_if.sink                        i_smp,
    swfn_res_if.source                      o_res,
    input  logic                            i_cfg_we,
    input  logic [swfn_pkg::WIN_BITS-1:0]   i_cfg_wdata
);
    import swfn_pkg::*;

    localparam int PW   = $clog2(2 * MAX_WINDOW);
    localparam int CW   = $clog2(MAX_WINDOW + 1);
    localparam int WW   = (CW > WIN_BITS) ? CW : WIN_BITS;
    localparam int CMPW = (WW > PW) ? WW : PW;
    localparam int XW   = (SAMPLE_BITS > RES_BITS) ? SAMPLE_BITS : RES_BITS;
    localparam int POS_MOD = 2 * MAX_WINDOW;

    // Configuration
    logic [WIN_BITS-1:0] r_window;

    // Input register
    logic                   r_in_vld;
    logic [SAMPLE_BITS-1:0] r_in_sample;
    logic                   r_in_eos;

    // Sequence counters
    logic [PW-1:0] r_pos, n_pos;
    logic [PW-1:0] r_seen, n_seen;

    // Result register
    logic                r_out_vld, n_out_vld;
    logic [RES_BITS-1:0] r_out_fn;
    logic                r_out_eos;

    logic                   out_free;
    logic                   step;
    logic [CMPW-1:0]        w_eff;
    logic [PW:0]            age_wide;
    logic [PW-1:0]          age;
    logic [PW-1:0]          seen_inc;
    logic                   emit;
    t_fifo_ctl              fifo_ctl;
    logic                   head_vld;
    logic [PW-1:0]          head_pos;
    logic                   nxt_vld;
    logic [SAMPLE_BITS-1:0] nxt_val;
    logic [XW-1:0]          nxt_ext;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= WINDOW_RST;
        end else if (i_cfg_we) begin
            r_window <= i_cfg_wdata;
        end
    end

    // Advance the sample only when the result slot is free or draining
    assign out_free    = !r_out_vld || o_res.ready;
    assign step        = r_in_vld && out_free;
    assign i_smp.ready = !r_in_vld || step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_smp.ready) begin
            r_in_vld <= i_smp.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_smp.ready && i_smp.valid) begin
            r_in_sample <= i_smp.sample;
            r_in_eos    <= i_smp.end_of_sequence;
        end
    end

    // Clamp the window to the queue depth
    assign w_eff = (CMPW'(r_window) > CMPW'(MAX_WINDOW)) ? CMPW'(MAX_WINDOW)
                                                         : CMPW'(r_window);

    // Age of the head entry, modulo twice the depth
    assign age_wide = {1'b0, r_pos} - {1'b0, head_pos};
    assign age = (r_pos >= head_pos) ? age_wide[PW-1:0]
                                     : PW'(age_wide + (PW+1)'(POS_MOD));

    assign seen_inc = (r_seen != PW'(POS_MOD - 1)) ? r_seen + PW'(1) : r_seen;
    assign emit     = (w_eff != '0) && (CMPW'(seen_inc) >= w_eff);

    always_comb begin
        fifo_ctl.pop   = step && head_vld && (CMPW'(age) >= w_eff);
        fifo_ctl.push  = step && r_in_sample[SAMPLE_BITS-1];
        fifo_ctl.clear = step && r_in_eos;
    end

    swfn_fifo #(
        .MAX_WINDOW  (MAX_WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS),
        .PW          (PW)
    ) u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (fifo_ctl),
        .i_wr_val   (r_in_sample),
        .i_wr_pos   (r_pos),
        .o_head_vld (head_vld),
        .o_head_pos (head_pos),
        .o_nxt_vld  (nxt_vld),
        .o_nxt_val  (nxt_val)
    );

    // Advance position and sample count; drop both at end of sequence
    always_comb begin
        n_pos  = r_pos;
        n_seen = r_seen;
        if (step) begin
            if (r_in_eos) begin
                n_pos  = '0;
                n_seen = '0;
            end else begin
                n_pos  = (r_pos == PW'(POS_MOD - 1)) ? '0 : r_pos + PW'(1);
                n_seen = seen_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_seen <= '0;
        end else begin
            r_pos  <= n_pos;
            r_seen <= n_seen;
        end
    end

    // Result register: load on a step that emits, clear once taken
    always_comb begin
        n_out_vld = r_out_vld;
        if (step) begin
            n_out_vld = emit;
        end else if (o_res.ready) begin
            n_out_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= n_out_vld;
        end
    end

    // The sample bits are taken as an unsigned pattern and cut to the result width
    assign nxt_ext = XW'(nxt_val);

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out_fn  <= nxt_vld ? nxt_ext[RES_BITS-1:0] : '0;
            r_out_eos <= r_in_eos;
        end
    end

    assign o_res.valid          = r_out_vld;
    assign o_res.first_negative = r_out_fn;
    assign o_res.sequence_end   = r_out_eos;

endmodule

FILE: src/swfn_chk.sv
`timescale 1ns / 1ps

module swfn_chk #(
    parameter int SAMPLE_BITS = swfn_pkg::SAMPLE_BITS_DEF
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_ready,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic [swfn_pkg::RES_BITS-1:0] i_out_fn,
    input logic                          i_out_eos
);
    import swfn_pkg::*;

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_fn)
            && $stable(i_out_eos))
        else $error("result changed while stalled");

    // Input stalls only behind a stalled result
    a_in_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> i_out_valid && !i_out_ready)
        else $error("input stalled without a stalled result");

    // No result right after reset
    a_rst_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_rst_n) |-> !i_out_valid)
        else $error("result present right after reset");

    // A reported sample is negative or the empty-window zero; a sample width
    // other than the result width gives a raw bit pattern instead
    a_fn_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (SAMPLE_BITS != RES_BITS) || i_out_fn[RES_BITS-1]
            || (i_out_fn == '0))
        else $error("positive first_negative");

endmodule

bind sliding_window_first_negative swfn_chk #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_swfn_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_smp.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_out_fn    (o_res.first_negative),
    .i_out_eos   (o_res.sequence_end)
);
